### sv/ezaf_pkg.sv
// shared types for the ewma z-score anomaly filter
// request and result payloads, controller states and datapath commands
package ezaf_pkg;

  localparam logic [15:0] SMOOTHING_RESET = 16'd3277;
  localparam logic [15:0] THRESHOLD_RESET = 16'd512;
  localparam logic [15:0] WARMUP_RESET    = 16'd20;
  localparam logic [16:0] SCORE_ONE       = 17'h10000;
  localparam logic [4:0]  SQRT_STEPS      = 5'd24;
  localparam logic [4:0]  DIV_STEPS       = 5'd16;

  typedef enum logic [1:0] {
    CFG_SMOOTHING = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WARMUP    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        action;
    logic [23:0] sample;
  } ezaf_req_t;

  typedef struct packed {
    logic [16:0] score;
    logic        anomalous;
    logic        warming_up;
    logic [23:0] threshold;
  } ezaf_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MULK,
    ST_THR,
    ST_DIV,
    ST_RES,
    ST_FIRST,
    ST_M_DD,
    ST_M_ADL,
    ST_M_ADH,
    ST_A_ADH,
    ST_T_SUM,
    ST_M_TL,
    ST_M_TH,
    ST_A_TH,
    ST_V_WR,
    ST_M_AS,
    ST_A_AS,
    ST_M_WR
  } ezaf_state_t;

  typedef enum logic [2:0] {
    MS_KSD,
    MS_DD,
    MS_ADL,
    MS_ADH,
    MS_TL,
    MS_TH,
    MS_IAM,
    MS_AS
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic     load;
    logic     sqrt_step;
    logic     thr_ld;
    logic     div_step;
    logic     res_ld;
    logic     dd_ld;
    logic     t_ld;
    logic     var_ld;
    logic     mean_ld;
    logic     first_ld;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } ezaf_cmd_t;

  typedef struct packed {
    logic action;
    logic first;
    logic res_free;
  } ezaf_sts_t;

endpackage

### sv/ewma_zscore_anomaly_filter.sv
// Scores each unsigned Q8.16 sample against an exponentially weighted mean
// and variance and, when the action bit is set, folds the sample in. One
// request is worked at a time. Its score comes from the 24-step bit-serial
// square root and the 16-step restoring divider; the single shared 24x24
// multiplier sequences the fold. The result register lets a new request be
// accepted while the previous result waits. Config writes are always ready.
module ewma_zscore_anomaly_filter import ezaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ezaf_req_t   in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output ezaf_rsp_t   out_rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ezaf_cmd_t cmd;
  ezaf_sts_t sts;

  assign cfg_ready = 1'b1;

  ezaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ezaf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

### sv/ezaf_dp.sv
// datapath: statistics, config registers, bit-serial sqrt and divider,
// shared multiplier with accumulator, result register; uses ezaf_pkg
module ezaf_dp import ezaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ezaf_cmd_t   cmd,
  output ezaf_sts_t   sts,
  input  ezaf_req_t   in_req,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output ezaf_rsp_t   out_rsp
);

  logic [15:0] alpha, kf, warmup;
  logic [15:0] count;
  logic [23:0] mean;
  logic [47:0] var_q;
  logic        action;
  logic [23:0] sample;
  logic        warm;
  logic [47:0] rem, root, bitr;
  logic [47:0] p;
  logic [23:0] dd;
  logic [47:0] t;
  logic [65:0] acc;
  logic [23:0] thr;
  logic [40:0] r;
  logic [15:0] q;
  logic        over, pos;

  logic [48:0] sq_try;
  logic [23:0] ma, mb, dabs;
  logic [16:0] ia;
  logic [32:0] thr_sum;
  logic [23:0] dpos;
  logic [40:0] r2;
  logic [48:0] t_sum;
  logic [16:0] score;

  assign ia     = SCORE_ONE - {1'b0, alpha};
  assign dabs   = (sample >= mean) ? sample - mean : mean - sample;
  assign dpos   = sample - mean;
  assign sq_try = {1'b0, root} + {1'b0, bitr};
  assign thr_sum = {9'd0, mean} + {1'b0, p[39:8]};
  assign r2     = {r[39:0], 1'b0};
  assign t_sum  = {1'b0, var_q} + {1'b0, acc[63:16]};
  assign score  = (warm || !pos) ? 17'd0 : (over ? SCORE_ONE : {1'b0, q});

  always_comb begin
    case (cmd.mul_sel)
      MS_KSD: begin ma = {8'd0, kf};      mb = root[23:0]; end
      MS_DD:  begin ma = dabs;            mb = dabs;       end
      MS_ADL: begin ma = {8'd0, alpha};   mb = p[23:0];    end
      MS_ADH: begin ma = {8'd0, alpha};   mb = dd;         end
      MS_TL:  begin ma = {7'd0, ia};      mb = t[23:0];    end
      MS_TH:  begin ma = {7'd0, ia};      mb = t[47:24];   end
      MS_IAM: begin ma = {7'd0, ia};      mb = mean;       end
      MS_AS:  begin ma = {8'd0, alpha};   mb = sample;     end
      default: begin ma = '0;             mb = '0;         end
    endcase
  end

  assign sts.action   = action;
  assign sts.first    = (count == 16'd0);
  assign sts.res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= SMOOTHING_RESET;
      kf     <= THRESHOLD_RESET;
      warmup <= WARMUP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMOOTHING: alpha  <= cfg_data;
        CFG_THRESHOLD: kf     <= cfg_data;
        CFG_WARMUP:    warmup <= cfg_data;
        default: ;
      endcase
    end
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      var_q <= '0;
    end else begin
      if (cmd.first_ld) begin
        mean  <= sample;
        var_q <= '0;
      end
      if (cmd.var_ld) var_q <= acc[63:16];
      if (cmd.mean_ld) mean <= acc[39:16];
      if ((cmd.first_ld || cmd.mean_ld) && count != 16'hFFFF) count <= count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (cmd.load) begin
      action <= in_req.action;
      sample <= in_req.sample;
      warm   <= count < warmup;
      rem    <= (var_q == 48'd0) ? 48'd1 : var_q;
      root   <= '0;
      bitr   <= 48'd1 << 46;
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, rem} >= sq_try) begin
        rem  <= rem - sq_try[47:0];
        root <= (root >> 1) + bitr;
      end else begin
        root <= root >> 1;
      end
      bitr <= bitr >> 2;
    end
    if (cmd.thr_ld) begin
      thr  <= (thr_sum > 33'hFFFFFF) ? 24'hFFFFFF : thr_sum[23:0];
      pos  <= sample > mean;
      over <= {10'd0, dpos, 7'd0} >= {1'b0, p[39:0]};
      r    <= {10'd0, dpos, 7'd0};
      q    <= '0;
    end
    if (cmd.div_step) begin
      if (r2 >= {1'b0, p[39:0]}) begin
        r <= r2 - {1'b0, p[39:0]};
        q <= {q[14:0], 1'b1};
      end else begin
        r <= r2;
        q <= {q[14:0], 1'b0};
      end
    end
    if (cmd.res_ld) begin
      out_rsp.score      <= score;
      out_rsp.anomalous  <= !warm && (sample > thr);
      out_rsp.warming_up <= warm;
      out_rsp.threshold  <= thr;
    end
    if (cmd.dd_ld) dd <= p[47:24];
    if (cmd.t_ld) t <= t_sum[48] ? 48'hFFFFFFFFFFFF : t_sum[47:0];
    case (cmd.acc_op)
      ACC_INIT:   acc <= 66'd32768;
      ACC_ADD:    acc <= acc + {18'd0, p};
      ACC_ADD_HI: acc <= acc + {p[41:0], 24'd0};
      default:    acc <= acc;
    endcase
  end

endmodule

### sv/ezaf_ctrl.sv
// controller: sequences the sqrt, divide, result and fold steps
// drives ezaf_dp through command and status structs from ezaf_pkg
module ezaf_ctrl import ezaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ezaf_sts_t sts,
  output ezaf_cmd_t cmd
);

  ezaf_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MS_KSD;
    cmd.acc_op  = ACC_HOLD;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 5'd1;
        if (cnt == SQRT_STEPS - 5'd1) state_next = ST_MULK;
      end
      ST_MULK: begin
        cmd.mul_sel = MS_KSD;
        state_next  = ST_THR;
      end
      ST_THR: begin
        cmd.thr_ld = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == DIV_STEPS - 5'd1) state_next = ST_RES;
      end
      ST_RES: begin
        if (sts.res_free) begin
          cmd.res_ld = 1'b1;
          if (!sts.action) state_next = ST_IDLE;
          else if (sts.first) state_next = ST_FIRST;
          else state_next = ST_M_DD;
        end
      end
      ST_FIRST: begin
        cmd.first_ld = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_M_DD: begin
        cmd.mul_sel = MS_DD;
        cmd.acc_op  = ACC_INIT;
        state_next  = ST_M_ADL;
      end
      ST_M_ADL: begin
        cmd.dd_ld   = 1'b1;
        cmd.mul_sel = MS_ADL;
        state_next  = ST_M_ADH;
      end
      ST_M_ADH: begin
        cmd.mul_sel = MS_ADH;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_A_ADH;
      end
      ST_A_ADH: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = ST_T_SUM;
      end
      ST_T_SUM: begin
        cmd.t_ld   = 1'b1;
        cmd.acc_op = ACC_INIT;
        state_next = ST_M_TL;
      end
      ST_M_TL: begin
        cmd.mul_sel = MS_TL;
        state_next  = ST_M_TH;
      end
      ST_M_TH: begin
        cmd.mul_sel = MS_TH;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_A_TH;
      end
      ST_A_TH: begin
        cmd.mul_sel = MS_IAM;
        cmd.acc_op  = ACC_ADD_HI;
        state_next  = ST_V_WR;
      end
      ST_V_WR: begin
        cmd.var_ld  = 1'b1;
        cmd.mul_sel = MS_AS;
        cmd.acc_op  = ACC_INIT;
        state_next  = ST_M_AS;
      end
      ST_M_AS: begin
        cmd.mul_sel = MS_IAM;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_A_AS;
      end
      ST_A_AS: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_M_WR;
      end
      ST_M_WR: begin
        cmd.mean_ld = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### bench/ezaf_checker.sv
`timescale 1ns / 1ps
// request/result checker for the ewma z-score anomaly filter
// depends on ezaf_pkg; predicts each result from its own copy of the statistics
module ezaf_checker import ezaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  ezaf_req_t   in_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  ezaf_rsp_t   out_rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  logic [15:0] alpha, kfac, warm_n;
  logic [15:0] obs_cnt;
  logic [23:0] mean_q;
  logic [47:0] var_q;
  ezaf_rsp_t   expected_rsp[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem = v;
    root = 0;
    b = 64'd1 << 46;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic ezaf_rsp_t score_sample(logic [23:0] s);
    ezaf_rsp_t   r;
    logic [63:0] sd, thr, q, den;
    logic        warm;
    sd = floor_sqrt((var_q == 0) ? 64'd1 : {16'd0, var_q});
    thr = mean_q + ((kfac * sd) >> 8);
    if (thr > 64'hFFFFFF) thr = 64'hFFFFFF;
    warm = obs_cnt < warm_n;
    r = '0;
    if (!warm) begin
      if (s > mean_q) begin
        den = sd * kfac;
        if (den == 0) q = SCORE_ONE;
        else q = ({40'd0, s - mean_q} << 23) / den;
        r.score = (q > SCORE_ONE) ? SCORE_ONE : q[16:0];
      end
      r.anomalous = s > thr;
    end
    r.warming_up = warm;
    r.threshold = thr[23:0];
    return r;
  endfunction

  task automatic fold_sample(logic [23:0] s);
    logic [127:0] d, t, ia;
    ia = 128'd65536 - alpha;
    if (obs_cnt == 0) begin
      mean_q <= s;
      var_q <= '0;
    end else begin
      d = (s >= mean_q) ? s - mean_q : mean_q - s;
      t = var_q + ((alpha * (d * d) + 32768) >> 16);
      if (t > 128'hFFFFFFFFFFFF) t = 128'hFFFFFFFFFFFF;
      mean_q <= 24'((ia * mean_q + alpha * s + 32768) >> 16);
      var_q <= 48'((ia * t + 32768) >> 16);
    end
    if (obs_cnt != 16'hFFFF) obs_cnt <= obs_cnt + 1;
  endtask

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    ezaf_rsp_t want;
    if (rst) begin
      errors = 0;
      alpha <= SMOOTHING_RESET;
      kfac <= THRESHOLD_RESET;
      warm_n <= WARMUP_RESET;
      obs_cnt <= '0;
      mean_q <= '0;
      var_q <= '0;
      expected_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_SMOOTHING: alpha <= cfg_data;
          CFG_THRESHOLD: kfac <= cfg_data;
          CFG_WARMUP:    warm_n <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_rsp.push_back(score_sample(in_req.sample));
        if (in_req.action) fold_sample(in_req.sample);
      end
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected result", 24'(out_rsp.score), 24'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.score != want.score) report("score", 24'(out_rsp.score), 24'(want.score));
          if (out_rsp.anomalous != want.anomalous)
            report("anomalous", 24'(out_rsp.anomalous), 24'(want.anomalous));
          if (out_rsp.warming_up != want.warming_up)
            report("warming_up", 24'(out_rsp.warming_up), 24'(want.warming_up));
          if (out_rsp.threshold != want.threshold)
            report("threshold", out_rsp.threshold, want.threshold);
        end
      end
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// top of the ewma z-score anomaly filter bench: clock, reset, stimulus and verdict
// depends on ezaf_pkg, ewma_zscore_anomaly_filter and ezaf_checker
module tb;
  import ezaf_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk, rst;
  logic        in_valid, in_stall;
  ezaf_req_t   in_req;
  logic        out_valid, out_stall;
  ezaf_rsp_t   out_rsp;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors, pending;
  int          burst_left, idle_cycles, stall_mode, stall_span;
  logic [23:0] center;

  ewma_zscore_anomaly_filter DUT (.*);

  ezaf_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: picks a new random mode each time its random span runs out
  always @(posedge clk) begin
    if (rst) begin
      stall_mode <= 0;
      stall_span <= 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_span <= $urandom_range(50, 400);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 80);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic act, logic [23:0] s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req <= '{action: act, sample: s};
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] a, logic [15:0] k, logic [15:0] w);
    drain();
    write_reg(CFG_SMOOTHING, a);
    write_reg(CFG_THRESHOLD, k);
    write_reg(CFG_WARMUP, w);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int n, r;
    logic [23:0] s;
    rst = 1;
    in_valid = 0;
    in_req = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: warm-up and first observation
    send(0, 24'hFFFFFF);
    send(1, 24'h010000);
    send(1, 24'h020000);
    send(0, 24'h000000);
    set_regs(16'd3277, 16'd512, 16'd2);
    send(1, 24'hFFFFFF);
    send(0, 24'hFFFFFF);
    send(0, 24'h000000);
    send(1, 24'h000000);
    send(0, 24'h800000);
    // zero threshold factor
    set_regs(16'd3277, 16'd0, 16'd0);
    send(0, 24'hFFFFFF);
    send(0, 24'h000000);
    // zero smoothing weight
    set_regs(16'd0, 16'hFFFF, 16'd0);
    send(1, 24'hFFFFFF);
    send(1, 24'h000000);
    send(0, 24'h7FFFFF);
    // variance overflow with full weight
    set_regs(16'hFFFF, 16'd1, 16'hFFFF);
    for (int i = 0; i < 6; i++) send(1, i[0] ? 24'hFFFFFF : 24'h000000);
    send(0, 24'h555555);
    set_regs(16'hFFFF, 16'd256, 16'd0);
    send(0, 24'hAAAAAA);
    send(1, 24'h123456);

    for (int ph = 0; ph < 10; ph++) begin
      set_regs(pick16(), pick16(), ($urandom_range(0, 3) == 0) ? pick16()
               : 16'($urandom_range(0, 30)));
      center = $urandom_range(0, 24'hFFFFFF);
      n = $urandom_range(100, 140);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) s = center + 24'($urandom_range(0, 4095)) - 24'd2048;
        else if (r < 90) s = center + 24'($urandom_range(0, 24'h0FFFFF));
        else s = $urandom_range(0, 24'hFFFFFF);
        send($urandom_range(0, 99) < 80, s);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ezaf_pkg.sv
sv/ezaf_dp.sv
sv/ezaf_ctrl.sv
sv/ewma_zscore_anomaly_filter.sv
bench/ezaf_checker.sv
bench/tb.sv
